[hw/rtl/bfmt_pkg.sv]
// Shared types, constants and helper functions of the base-30 float text formatter.
package bfmt_pkg;

    localparam int DEF_MAX_DIGITS = 12;
    localparam int DEF_WORK_WORDS = 36;
    localparam int FRAC_WORDS     = 17;

    // bit offset of the mantissa lsb inside the work number
    localparam logic [11:0] SHIFT_NORM = 12'(FRAC_WORDS * 64 - 1075);
    localparam logic [11:0] SHIFT_SUB  = 12'(FRAC_WORDS * 64 - 1074);

    localparam logic [3:0] SIG_DIGITS_RST  = 4'd12;
    localparam logic [8:0] FIELD_LIMIT_RST = 9'd20;

    localparam logic [7:0] CFG_IDX_SIG_DIGITS  = 8'd0;
    localparam logic [7:0] CFG_IDX_FIELD_LIMIT = 8'd1;

    localparam logic [4:0] RADIX      = 5'd30;
    localparam logic [4:0] HALF_DIGIT = 5'd15;
    localparam logic [4:0] TOP_DIGIT  = 5'd29;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        K_NAN, K_INF, K_ZERO, K_FIX_LO, K_FIX_HI, K_EXP
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE, S_CLEAR, S_DRD, S_DLD, S_DDIV, S_DWR, S_FRD, S_FMUL,
        S_SCAN0, S_SCAN, S_RND0, S_RND1, S_RINC, S_STRIP,
        S_LAY0, S_LAY1, S_LAY2, S_LAY3, S_LAY4, S_EMIT
    } t_state;

    // field layout handed to the character generator
    typedef struct packed {
        t_kind      kind;
        logic       neg;
        logic [3:0] n;
        logic       z;
        logic [4:0] tp;
        logic       exp_neg;
        logic [1:0] ecnt;
        logic [4:0] e2;
        logic [4:0] e1;
        logic [4:0] e0;
    } t_layout;

    function automatic logic [7:0] trig_char(input logic [4:0] d);
        return (d < 5'd10) ? 8'(CH_ZERO + 8'(d)) : 8'(CH_A + 8'(d) - 8'd10);
    endfunction

    // one byte of long division by 30: returns {remainder, quotient byte}
    function automatic logic [12:0] div30_byte(input logic [7:0] b, input logic [4:0] r);
        logic [5:0] t;
        logic [4:0] rr;
        logic [7:0] q;
        rr = r;
        q  = '0;
        for (int i = 7; i >= 0; i--) begin
            t = {rr, b[i]};
            if (t >= 6'(RADIX)) begin
                rr   = 5'(t - 6'(RADIX));
                q[i] = 1'b1;
            end else begin
                rr = t[4:0];
            end
        end
        return {rr, q};
    endfunction

endpackage

[hw/rtl/bfmt_ifs.sv]
// Stream and configuration interfaces of the base-30 float text formatter.
interface bfmt_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_bits;
    modport source (output valid, output value_bits, input ready);
    modport sink   (input valid, input value_bits, output ready);
endinterface

interface bfmt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;
    logic       overflow;
    modport source (output valid, output out_char, output last, output overflow, input ready);
    modport sink   (input valid, input out_char, input last, input overflow, output ready);
endinterface

interface bfmt_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [8:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/bfmt_work_mem.sv]
// Work number memory: one write port, one registered read port.
module bfmt_work_mem #(
    parameter int WORK_WORDS = 36
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(WORK_WORDS)-1:0] i_waddr,
    input  logic [63:0]                   i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(WORK_WORDS)-1:0] i_raddr,
    output logic [63:0]                   o_rdata
);
    logic [63:0] mem [WORK_WORDS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

[hw/rtl/bfmt_emit.sv]
// Character generator: maps a field position to its character.
module bfmt_emit
    import bfmt_pkg::*;
(
    input  t_layout    i_lay,
    input  logic [4:0] i_k,
    input  logic [4:0] i_digit,
    output logic [3:0] o_dig_idx,
    output logic [7:0] o_char
);
    always_comb begin : p_char
        logic [5:0] j;
        logic [5:0] n6;
        logic [5:0] tp6;
        logic [5:0] q;
        logic [5:0] lim;
        logic [1:0] sel;
        j   = 6'(i_k) - 6'(i_lay.neg);
        n6  = 6'(i_lay.n);
        tp6 = 6'(i_lay.tp);
        q   = j - n6 - 6'd1;
        sel = 2'(6'(i_lay.ecnt) - 6'd1 - q);
        lim = 6'd2 + 6'(i_lay.z) + n6;
        o_dig_idx = '0;
        o_char    = CH_SLASH;
        if (i_lay.kind == K_NAN) begin
            o_char = (i_k == 5'd0) ? CH_STAR : CH_DOT;
        end else if (i_lay.neg && i_k == 5'd0) begin
            o_char = CH_MINUS;
        end else begin
            unique case (i_lay.kind)
                K_INF: begin
                    unique case (j)
                        6'd0:       o_char = CH_ONE;
                        6'd1:       o_char = CH_PLUS;
                        6'd2, 6'd3: o_char = CH_T;
                        default:    o_char = CH_SLASH;
                    endcase
                end
                K_ZERO: begin
                    o_char = (j == 6'd0) ? CH_ZERO : CH_SLASH;
                end
                K_FIX_LO: begin
                    if (j == 6'd0) begin
                        o_char = CH_ZERO;
                    end else if (j == 6'd1) begin
                        o_char = CH_DOT;
                    end else if (i_lay.z && j == 6'd2) begin
                        o_char = CH_ZERO;
                    end else if (j < lim) begin
                        o_dig_idx = 4'(j - 6'd2 - 6'(i_lay.z));
                        o_char    = trig_char(i_digit);
                    end
                end
                K_FIX_HI: begin
                    if (j < tp6) begin
                        if (j < n6) begin
                            o_dig_idx = 4'(j);
                            o_char    = trig_char(i_digit);
                        end else begin
                            o_char = CH_ZERO;
                        end
                    end else if (n6 > tp6 && j == tp6) begin
                        o_char = CH_DOT;
                    end else if (n6 > tp6 && j <= n6) begin
                        o_dig_idx = 4'(j - 6'd1);
                        o_char    = trig_char(i_digit);
                    end
                end
                K_EXP: begin
                    if (j < n6) begin
                        o_dig_idx = 4'(j);
                        o_char    = trig_char(i_digit);
                    end else if (j == n6) begin
                        o_char = i_lay.exp_neg ? CH_MINUS : CH_PLUS;
                    end else if (q < 6'(i_lay.ecnt)) begin
                        unique case (sel)
                            2'd0:    o_char = trig_char(i_lay.e0);
                            2'd1:    o_char = trig_char(i_lay.e1);
                            default: o_char = trig_char(i_lay.e2);
                        endcase
                    end
                end
                default: o_char = CH_SLASH;
            endcase
        end
    end
endmodule

[hw/rtl/base30_float_text_formatter_unit.sv]
// Top level of the base-30 float text formatter: sequencer, digit buffer and output stage.
//
// Usage: i_in carries one binary64 bit pattern per transaction; o_out returns
// the base-30 text field one character per transaction, last set on the final
// character; a field that does not fit field_limit gives one transaction with
// out_char 0, last 1 and overflow 1. i_cfg writes significant_digits (index 0)
// and field_limit (index 1); other indexes are dropped; it is always ready.
// One item is in work at a time; i_in is ready only while the sequencer idles.
// Steps per finite item: a clear pass over all WORK_WORDS, then one divide-by-30
// pass over the WORK_WORDS-17 integer words per integer digit, a byte at a time on
// the byte-serial divider, then one multiply-by-30 pass over the 17 fraction words
// per fraction digit, one word a cycle, then a sticky scan of the fraction words,
// rounding and layout, then one character per cycle while the receiver is ready.
// NaN, infinity and zero skip the memory and go straight to the field length
// step. The work memory has a single read port.
// Reset clears the sequencer and output stage and loads 12 and 20 into the
// registers; the work memory holds no reset value and is rewritten per item.
// A stalled receiver holds the output register; the sequencer waits with it.
module base30_float_text_formatter_unit
    import bfmt_pkg::*;
#(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS,
    parameter int WORK_WORDS = DEF_WORK_WORDS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bfmt_in_if.sink       i_in,
    bfmt_out_if.source    o_out,
    bfmt_cfg_if.sink      i_cfg
);
    localparam int CAP = MAX_DIGITS + 1;
    localparam int DIW = $clog2(CAP);
    localparam int AW  = $clog2(WORK_WORDS);
    localparam logic [AW-1:0] TOP_ADDR = AW'(WORK_WORDS - 1);
    localparam logic [AW-1:0] FRAC_LO  = AW'(FRAC_WORDS);
    localparam logic [AW-1:0] FRAC_TOP = AW'(FRAC_WORDS - 1);
    localparam logic [3:0]    CAP_N    = 4'(CAP);
    localparam logic [3:0]    MAX_N    = 4'(MAX_DIGITS);

    t_state r_state, n_state;

    // work memory port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [63:0]   mem_q;

    // sequencer registers
    logic [AW-1:0]      r_addr, n_addr;
    logic [63:0]        r_w, n_w;
    logic [4:0]         r_rem, n_rem;
    logic [2:0]         r_step, n_step;
    logic               r_qnz, n_qnz;
    logic [4:0]         r_carry, n_carry;
    logic [3:0]         r_cnt, n_cnt;
    logic [4:0]         r_dig [CAP];
    logic [4:0]         n_dig [CAP];
    logic signed [11:0] r_radix, n_radix;
    logic               r_sticky, n_sticky;
    logic [3:0]         r_n, n_n;
    logic [3:0]         r_i, n_i;
    logic [4:0]         r_dp, n_dp;
    logic               r_rest, n_rest;
    t_layout            r_lay, n_lay;
    logic [11:0]        r_mag, n_mag;
    logic [7:0]         r_q1, n_q1;
    logic [7:0]         r_q2, n_q2;
    logic [5:0]         r_len, n_len;
    logic               r_err, n_err;
    logic [4:0]         r_k, n_k;
    logic [63:0]        r_place_lo, n_place_lo;
    logic [63:0]        r_place_hi, n_place_hi;
    logic [6:0]         r_pidx, n_pidx;
    logic               r_int_nz, n_int_nz;

    // configuration
    logic [3:0] r_sd;
    logic [8:0] r_limit;

    // output register
    logic       r_o_valid, n_o_valid;
    logic [7:0] r_o_char, n_o_char;
    logic       r_o_last, n_o_last;
    logic       r_o_ovf, n_o_ovf;

    // input decode and mantissa placement
    logic         in_acc;
    logic [10:0]  in_ex;
    logic [51:0]  in_man;
    logic [52:0]  in_m;
    logic [11:0]  in_s;
    logic [127:0] in_wide;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign in_ex      = i_in.value_bits[62:52];
    assign in_man     = i_in.value_bits[51:0];
    assign in_m       = {(in_ex != 11'd0), in_man};
    assign in_s       = (in_ex != 11'd0) ? 12'(12'(in_ex) + SHIFT_NORM) : SHIFT_SUB;
    assign in_wide    = 128'(in_m) << in_s[5:0];

    // digit buffer read port and character generator
    logic [3:0] p_eff;
    logic [3:0] rd_idx;
    logic [4:0] dq;
    logic [3:0] e_idx;
    logic [7:0] e_char;

    assign p_eff = (r_sd == 4'd0 || r_sd > MAX_N) ? MAX_N : r_sd;

    always_comb begin
        unique case (r_state)
            S_RND0:          rd_idx = p_eff;
            S_RND1, S_STRIP: rd_idx = r_n - 4'd1;
            S_RINC:          rd_idx = r_i;
            S_EMIT:          rd_idx = e_idx;
            default:         rd_idx = '0;
        endcase
    end

    assign dq = r_dig[rd_idx[DIW-1:0]];

    bfmt_emit u_emit (
        .i_lay     (r_lay),
        .i_k       (r_k),
        .i_digit   (dq),
        .o_dig_idx (e_idx),
        .o_char    (e_char)
    );

    bfmt_work_mem #(
        .WORK_WORDS (WORK_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    // layout helpers
    logic signed [11:0] lay_e;
    logic               lay_fixed;
    assign lay_e     = r_radix - $signed(12'(r_n));
    assign lay_fixed = (r_radix >= -12'sd1) && (r_radix < $signed(12'(r_n) + 12'd3));

    always_comb begin : p_next
        logic [12:0] dv;
        logic [68:0] prod;
        logic [63:0] clr_data;
        logic [4:0]  d;
        logic        up;
        logic        rest;
        logic [5:0]  body;
        logic        slot_free;

        n_state    = r_state;
        n_addr     = r_addr;
        n_w        = r_w;
        n_rem      = r_rem;
        n_step     = r_step;
        n_qnz      = r_qnz;
        n_carry    = r_carry;
        n_cnt      = r_cnt;
        n_dig      = r_dig;
        n_radix    = r_radix;
        n_sticky   = r_sticky;
        n_n        = r_n;
        n_i        = r_i;
        n_dp       = r_dp;
        n_rest     = r_rest;
        n_lay      = r_lay;
        n_mag      = r_mag;
        n_q1       = r_q1;
        n_q2       = r_q2;
        n_len      = r_len;
        n_err      = r_err;
        n_k        = r_k;
        n_place_lo = r_place_lo;
        n_place_hi = r_place_hi;
        n_pidx     = r_pidx;
        n_int_nz   = r_int_nz;
        n_o_valid  = r_o_valid && !o_out.ready;
        n_o_char   = r_o_char;
        n_o_last   = r_o_last;
        n_o_ovf    = r_o_ovf;

        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_w;
        mem_re    = 1'b0;
        mem_raddr = r_addr;

        dv        = div30_byte(r_w[63:56], r_rem);
        // word * 30 + carry as 32x - 2x
        prod      = {mem_q, 5'b0} - {4'b0, mem_q, 1'b0} + 69'(r_carry);
        clr_data  = ((7'(r_addr) == r_pidx) ? r_place_lo : 64'd0) |
                    ((7'(r_addr) == 7'(r_pidx + 7'd1)) ? r_place_hi : 64'd0);
        d         = prod[68:64];
        up        = 1'b0;
        rest      = r_sticky;
        body      = '0;
        slot_free = !r_o_valid || o_out.ready;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_lay.neg = i_in.value_bits[63];
                    n_k       = '0;
                    if (in_ex == 11'h7FF) begin
                        n_lay.kind = (in_man != 52'd0) ? K_NAN : K_INF;
                        n_state    = S_LAY4;
                    end else if (in_ex == 11'd0 && in_man == 52'd0) begin
                        n_lay.kind = K_ZERO;
                        n_state    = S_LAY4;
                    end else begin
                        n_place_lo = in_wide[63:0];
                        n_place_hi = in_wide[127:64];
                        n_pidx     = 7'(in_s[11:6]);
                        n_addr     = '0;
                        n_int_nz   = 1'b0;
                        n_cnt      = '0;
                        n_sticky   = 1'b0;
                        n_radix    = '0;
                        n_state    = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = clr_data;
                if (r_addr >= FRAC_LO && clr_data != 64'd0) begin
                    n_int_nz = 1'b1;
                end
                if (r_addr == TOP_ADDR) begin
                    if (n_int_nz) begin
                        n_addr  = TOP_ADDR;
                        n_rem   = '0;
                        n_qnz   = 1'b0;
                        n_state = S_DRD;
                    end else begin
                        n_addr  = '0;
                        n_state = S_FRD;
                    end
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_DRD: begin
                mem_re  = 1'b1;
                n_state = S_DLD;
            end
            S_DLD: begin
                n_w     = mem_q;
                n_step  = '0;
                n_state = S_DDIV;
            end
            S_DDIV: begin
                n_w    = {r_w[55:0], dv[7:0]};
                n_rem  = dv[12:8];
                n_step = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    n_state = S_DWR;
                end
            end
            S_DWR: begin
                mem_we = 1'b1;
                if (r_w != 64'd0) begin
                    n_qnz = 1'b1;
                end
                if (r_addr == FRAC_LO) begin
                    // integer pass done: remainder is the next more significant digit
                    if (r_cnt == CAP_N) begin
                        if (r_dig[CAP-1] != 5'd0) begin
                            n_sticky = 1'b1;
                        end
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                    end
                    for (int i = CAP - 1; i > 0; i--) begin
                        n_dig[i] = r_dig[i-1];
                    end
                    n_dig[0] = r_rem;
                    n_radix  = r_radix + 12'sd1;
                    if (n_qnz) begin
                        n_addr  = TOP_ADDR;
                        n_rem   = '0;
                        n_qnz   = 1'b0;
                        n_state = S_DRD;
                    end else if (n_cnt == CAP_N) begin
                        n_addr  = '0;
                        n_state = S_SCAN0;
                    end else begin
                        n_addr  = '0;
                        n_state = S_FRD;
                    end
                end else begin
                    n_addr  = r_addr - AW'(1);
                    n_state = S_DRD;
                end
            end
            S_FRD: begin
                mem_re  = 1'b1;
                n_carry = '0;
                n_state = S_FMUL;
            end
            S_FMUL: begin
                mem_we    = 1'b1;
                mem_wdata = prod[63:0];
                n_carry   = d;
                if (r_addr != FRAC_TOP) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_addr + AW'(1);
                    n_addr    = r_addr + AW'(1);
                end else begin
                    n_addr = '0;
                    if (r_cnt == 4'd0 && d == 5'd0) begin
                        // leading zero digit: shift the radix point instead
                        n_radix = r_radix - 12'sd1;
                        n_state = S_FRD;
                    end else begin
                        n_dig[r_cnt[DIW-1:0]] = d;
                        n_cnt = r_cnt + 4'd1;
                        n_state = (n_cnt == CAP_N) ? S_SCAN0 : S_FRD;
                    end
                end
            end
            S_SCAN0: begin
                mem_re  = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (mem_q != 64'd0) begin
                    n_sticky = 1'b1;
                end
                if (r_addr != FRAC_TOP) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_addr + AW'(1);
                    n_addr    = r_addr + AW'(1);
                end else begin
                    n_state = S_RND0;
                end
            end
            S_RND0: begin
                for (int i = 0; i < CAP; i++) begin
                    if (4'(i) > p_eff && r_dig[i] != 5'd0) begin
                        rest = 1'b1;
                    end
                end
                n_rest  = rest;
                n_dp    = dq;
                n_n     = p_eff;
                n_state = S_RND1;
            end
            S_RND1: begin
                up = (r_dp > HALF_DIGIT) ||
                     ((r_dp == HALF_DIGIT) && (r_rest || dq[0]));
                if (up) begin
                    n_i     = r_n - 4'd1;
                    n_state = S_RINC;
                end else begin
                    n_state = S_STRIP;
                end
            end
            S_RINC: begin
                if (dq == TOP_DIGIT) begin
                    n_dig[r_i[DIW-1:0]] = 5'd0;
                    if (r_i == 4'd0) begin
                        // carry out of every digit: the field becomes a single 1
                        n_dig[0] = 5'd1;
                        n_n      = 4'd1;
                        n_radix  = r_radix + 12'sd1;
                        n_state  = S_STRIP;
                    end else begin
                        n_i = r_i - 4'd1;
                    end
                end else begin
                    n_dig[r_i[DIW-1:0]] = 5'(dq + 5'd1);
                    n_state = S_STRIP;
                end
            end
            S_STRIP: begin
                if (r_n > 4'd1 && dq == 5'd0) begin
                    n_n = r_n - 4'd1;
                end else begin
                    n_state = S_LAY0;
                end
            end
            S_LAY0: begin
                n_lay.n       = r_n;
                n_lay.z       = (r_radix == -12'sd1);
                n_lay.tp      = r_radix[4:0];
                n_lay.exp_neg = lay_e[11];
                if (lay_fixed) begin
                    n_lay.kind = (r_radix <= 12'sd0) ? K_FIX_LO : K_FIX_HI;
                end else begin
                    n_lay.kind = K_EXP;
                end
                n_mag   = lay_e[11] ? 12'(-lay_e) : 12'(lay_e);
                n_state = S_LAY1;
            end
            S_LAY1: begin
                n_q1    = 8'((24'(r_mag) * 24'd2185) >> 16);
                n_state = S_LAY2;
            end
            S_LAY2: begin
                n_lay.e0 = 5'(r_mag - 12'(r_q1) * 12'd30);
                n_q2     = 8'((20'(r_q1) * 20'd2185) >> 16);
                n_state  = S_LAY3;
            end
            S_LAY3: begin
                n_lay.e1 = 5'(r_q1 - 8'(r_q2 * 8'd30));
                n_lay.e2 = 5'(r_q2);
                if (r_mag < 12'd30) begin
                    n_lay.ecnt = 2'd1;
                end else if (r_q1 < 8'd30) begin
                    n_lay.ecnt = 2'd2;
                end else begin
                    n_lay.ecnt = 2'd3;
                end
                n_state = S_LAY4;
            end
            S_LAY4: begin
                unique case (r_lay.kind)
                    K_NAN:    body = 6'd1;
                    K_INF:    body = 6'd4;
                    K_ZERO:   body = 6'd1;
                    K_FIX_LO: body = 6'd2 + 6'(r_lay.z) + 6'(r_lay.n);
                    K_FIX_HI: body = (r_lay.n > 4'(r_lay.tp)) ?
                                     6'(r_lay.n) + 6'd1 : 6'(r_lay.tp);
                    K_EXP:    body = 6'(r_lay.n) + 6'd1 + 6'(r_lay.ecnt);
                    default:  body = 6'd1;
                endcase
                // NaN has no sign and no terminator of its own: '*' '.'
                n_len   = (r_lay.kind == K_NAN) ? 6'd2 : body + 6'd1 + 6'(r_lay.neg);
                n_err   = (9'(n_len) + 9'd1) > r_limit;
                n_k     = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_o_valid = 1'b1;
                    if (r_err) begin
                        n_o_char = 8'd0;
                        n_o_last = 1'b1;
                        n_o_ovf  = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_o_char = e_char;
                        n_o_last = (6'(r_k) == r_len - 6'd1);
                        n_o_ovf  = 1'b0;
                        n_k      = r_k + 5'd1;
                        if (n_o_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_radix   <= '0;
            r_sticky  <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_radix   <= n_radix;
            r_sticky  <= n_sticky;
            r_cnt     <= n_cnt;
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_w        <= n_w;
        r_rem      <= n_rem;
        r_step     <= n_step;
        r_qnz      <= n_qnz;
        r_carry    <= n_carry;
        r_dig      <= n_dig;
        r_n        <= n_n;
        r_i        <= n_i;
        r_dp       <= n_dp;
        r_rest     <= n_rest;
        r_lay      <= n_lay;
        r_mag      <= n_mag;
        r_q1       <= n_q1;
        r_q2       <= n_q2;
        r_len      <= n_len;
        r_err      <= n_err;
        r_k        <= n_k;
        r_place_lo <= n_place_lo;
        r_place_hi <= n_place_hi;
        r_pidx     <= n_pidx;
        r_int_nz   <= n_int_nz;
        r_o_char   <= n_o_char;
        r_o_last   <= n_o_last;
        r_o_ovf    <= n_o_ovf;
    end

    // configuration writes; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd    <= SIG_DIGITS_RST;
            r_limit <= FIELD_LIMIT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index == CFG_IDX_SIG_DIGITS) begin
                r_sd <= i_cfg.data[3:0];
            end else if (i_cfg.index == CFG_IDX_FIELD_LIMIT) begin
                r_limit <= i_cfg.data;
            end
        end
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.out_char = r_o_char;
    assign o_out.last     = r_o_last;
    assign o_out.overflow = r_o_ovf;

    // an error transaction is always a lone terminating zero
    a_ovf_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overflow) |-> (o_out.last && o_out.out_char == 8'd0))
        else $error("overflow transaction without last or with nonzero char");

    // digit count never passes the buffer depth
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_N)
        else $error("digit count beyond buffer depth");

    // an accepted item always starts work
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE))
        else $error("accepted item left the sequencer idle");

    // multiply pass and sticky scan stay within the fraction words
    a_frac_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FMUL || r_state == S_SCAN) |-> (r_addr <= FRAC_TOP))
        else $error("fraction pass address out of range");

endmodule
